### hdl/vrm_pkg.sv
// Shared types, constants and mirroring functions for the video RAM mirror
// and dirty tracker. Used by vrm_dirty_store and video_ram_mirror_dirty_tracker.
// No dependencies.
package vrm_pkg;

	// Physical nametable count and dirty matrix shape
	localparam int PHYS_TABLES = 4;
	localparam int DIRTY_ROWS  = 32;
	localparam int TIDX_W      = $clog2(PHYS_TABLES);

	// Nametable byte store: 1 KB per physical table
	localparam int TBL_SIZE  = 1024;
	localparam int TBL_DEPTH = PHYS_TABLES * TBL_SIZE;
	localparam int TBL_AW    = TIDX_W + 10;
	localparam int TILE_BYTES = 32 * 30;

	// Dirty rows are split over four banks by row modulo four
	localparam int DIRTY_BANKS = 4;
	localparam int DGRP_W      = $clog2(DIRTY_ROWS / DIRTY_BANKS);
	localparam int DADDR_W     = TIDX_W + DGRP_W;
	localparam int DDEPTH      = PHYS_TABLES * (DIRTY_ROWS / DIRTY_BANKS);

	// Mirroring modes
	localparam logic [2:0] MIR_VERT    = 3'd0;
	localparam logic [2:0] MIR_HORIZ   = 3'd1;
	localparam logic [2:0] MIR_SINGLE0 = 3'd2;
	localparam logic [2:0] MIR_SINGLE1 = 3'd3;

	typedef enum logic [1:0] {
		CMD_READ      = 2'd0,
		CMD_WRITE     = 2'd1,
		CMD_RD_DIRTY  = 2'd2,
		CMD_CLR_DIRTY = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		RGN_PATTERN,
		RGN_NAME,
		RGN_PALETTE
	} region_t;

	// Per-bank dirty update of the row group held in the store
	typedef struct packed {
		logic [DIRTY_BANKS-1:0]       we;
		logic [DIRTY_BANKS-1:0][31:0] mask;
	} dirty_upd_t;

	// Clear of all dirty rows of one table
	typedef struct packed {
		logic              en;
		logic [TIDX_W-1:0] tbl;
	} dirty_clr_t;

	// Logical quadrant to table index for a mirroring mode
	function automatic logic [1:0] mirror_table(input logic [2:0] mode, input logic [1:0] quad);
		logic [1:0] idx;
		case (mode)
			MIR_VERT:    idx = {1'b0, quad[1]};
			MIR_HORIZ:   idx = {1'b0, quad[0]};
			MIR_SINGLE0: idx = 2'd0;
			MIR_SINGLE1: idx = 2'd1;
			default:     idx = quad;
		endcase
		return idx;
	endfunction

	// Fold an index past the last physical table back by two
	function automatic logic [1:0] fit_table(input logic [1:0] idx);
		logic [1:0] res;
		res = idx;
		if (32'(idx) >= PHYS_TABLES)
			res = idx - 2'd2;
		return res;
	endfunction

endpackage

### hdl/video_ram_mirror_dirty_tracker.sv
// A transaction accepted into stage one moves on to the result register once that register is free.
// Throughput: one transaction per cycle unless rsp_ready stalls the result; each does one
// read-modify-write of the nametable RAM and the dirty banks, with the previous write forwarded
// around the RAM read register. Reset: asynchronous; mirror_mode returns to 0, palette and
// refresh flags clear at once, then a clearing pass zeroes the nametable RAM while req_ready
// stays low. Depends on vrm_pkg and vrm_dirty_store.
module video_ram_mirror_dirty_tracker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_wr_data,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [1:0]  command,
	input  logic [15:0] address,
	input  logic [7:0]  write_data,
	input  logic [1:0]  table_select,
	input  logic [4:0]  dirty_row,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [7:0]  read_data,
	output logic        handled,
	output logic [31:0] dirty_word,
	output logic        refresh_pending
);

	localparam logic [9:0] TILE_END = 10'(vrm_pkg::TILE_BYTES);

	logic [2:0]                         mirror_mode_q;
	logic                               clr_busy_q;
	logic [vrm_pkg::TBL_AW-1:0]         clr_cnt_q;
	logic                               req_acc;

	// Accept-side decode
	vrm_pkg::cmd_t                      cmd_in;
	logic [13:0]                        addr_in;
	vrm_pkg::region_t                   region_in;
	logic [vrm_pkg::TIDX_W-1:0]         tidx_in;
	logic [vrm_pkg::TIDX_W-1:0]         sel_in;
	logic [vrm_pkg::TBL_AW-1:0]         taddr_in;
	logic [9:0]                         aoff_in;
	logic [vrm_pkg::DGRP_W-1:0]         grp_in;
	logic [vrm_pkg::DADDR_W-1:0]        daddr_in;

	// Stage one
	logic                               s1_valid_q;
	logic                               s1_fire;
	vrm_pkg::cmd_t                      cmd_s1;
	logic [13:0]                        addr_s1;
	vrm_pkg::region_t                   region_s1;
	logic [7:0]                         wdata_s1;
	logic [vrm_pkg::TIDX_W-1:0]         tidx_s1;
	logic [vrm_pkg::TIDX_W-1:0]         sel_s1;
	logic [4:0]                         row_s1;
	logic [vrm_pkg::TBL_AW-1:0]         taddr_s1;
	logic [7:0]                         tbl_rd_s1;
	logic                               fwd_tbl_s1;
	logic [7:0]                         fwd_byte_s1;

	logic [7:0]                         tbl_mem [vrm_pkg::TBL_DEPTH];
	logic                               tbl_we;
	logic [vrm_pkg::TBL_AW-1:0]         tbl_waddr;
	logic [7:0]                         tbl_wdata;
	logic                               nt_wr_s1;
	logic                               nt_wr_fire;

	logic [31:0][7:0]                   pal_q;
	logic [4:0]                         pslot_s1;
	logic [vrm_pkg::PHYS_TABLES-1:0]    refresh_q;

	logic [7:0]                         old_byte;
	logic [9:0]                         off_s1;
	logic [9:0]                         aoff_s1;
	logic                               tile_s1;
	logic                               changed;
	logic [3:0]                         fc;
	logic [31:0]                        tile_mask;
	logic [31:0]                        mask_top;
	logic [31:0]                        mask_bot;
	vrm_pkg::dirty_upd_t                upd;
	vrm_pkg::dirty_clr_t                clr;
	logic [vrm_pkg::DIRTY_BANKS-1:0][31:0] cur;

	logic [7:0]                         rd_nx;
	logic                               handled_nx;
	logic [31:0]                        word_nx;
	logic                               pend_nx;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mirror_mode_q <= vrm_pkg::MIR_VERT;
		end else if (cfg_wr_en) begin
			mirror_mode_q <= cfg_wr_data;
		end
	end

	// Zero the nametable RAM after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == vrm_pkg::TBL_AW'(vrm_pkg::TBL_DEPTH - 1))
				clr_busy_q <= 1'b0;
		end
	end

	// Handshake: stage one advances when the result register is free
	assign s1_fire   = s1_valid_q && (!rsp_valid || rsp_ready);
	assign req_ready = !clr_busy_q && (!s1_valid_q || s1_fire);
	assign req_acc   = req_valid && req_ready;

	// Decode the incoming transaction
	always_comb begin
		cmd_in  = vrm_pkg::cmd_t'(command);
		addr_in = address[13:0];
		if (!addr_in[13])
			region_in = vrm_pkg::RGN_PATTERN;
		else if (addr_in[13:8] == 6'h3F)
			region_in = vrm_pkg::RGN_PALETTE;
		else
			region_in = vrm_pkg::RGN_NAME;
		tidx_in  = vrm_pkg::TIDX_W'(vrm_pkg::fit_table(
			vrm_pkg::mirror_table(mirror_mode_q, addr_in[11:10])));
		sel_in   = vrm_pkg::TIDX_W'(vrm_pkg::fit_table(table_select));
		taddr_in = {tidx_in, addr_in[9:0]};
		aoff_in  = addr_in[9:0] - TILE_END;
		if (cmd_in == vrm_pkg::CMD_RD_DIRTY)
			grp_in = dirty_row[4:2];
		else if (addr_in[9:0] < TILE_END)
			grp_in = addr_in[9:7];
		else
			grp_in = aoff_in[5:3];
		daddr_in = {(cmd_in == vrm_pkg::CMD_RD_DIRTY) ? sel_in : tidx_in, grp_in};
	end

	// Stage one control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			fwd_tbl_s1 <= 1'b0;
		end else begin
			if (req_acc)
				s1_valid_q <= 1'b1;
			else if (s1_fire)
				s1_valid_q <= 1'b0;
			if (req_acc)
				fwd_tbl_s1 <= nt_wr_fire && (taddr_s1 == taddr_in);
		end
	end

	// Stage one payload
	always_ff @(posedge clk) begin
		if (req_acc) begin
			cmd_s1      <= cmd_in;
			addr_s1     <= addr_in;
			region_s1   <= region_in;
			wdata_s1    <= write_data;
			tidx_s1     <= tidx_in;
			sel_s1      <= sel_in;
			row_s1      <= dirty_row;
			taddr_s1    <= taddr_in;
			fwd_byte_s1 <= wdata_s1;
		end
	end

	// Nametable RAM: clearing pass or stage-one write, registered read
	assign nt_wr_s1   = (cmd_s1 == vrm_pkg::CMD_WRITE) && (region_s1 == vrm_pkg::RGN_NAME);
	assign nt_wr_fire = s1_fire && nt_wr_s1;
	assign tbl_we     = clr_busy_q || nt_wr_fire;
	assign tbl_waddr  = clr_busy_q ? clr_cnt_q : taddr_s1;
	assign tbl_wdata  = clr_busy_q ? 8'd0 : wdata_s1;

	always_ff @(posedge clk) begin
		if (tbl_we)
			tbl_mem[tbl_waddr] <= tbl_wdata;
	end

	always_ff @(posedge clk) begin
		if (req_acc)
			tbl_rd_s1 <= tbl_mem[taddr_in];
	end

	// Work out dirty masks from the old and new byte
	always_comb begin
		old_byte  = fwd_tbl_s1 ? fwd_byte_s1 : tbl_rd_s1;
		off_s1    = addr_s1[9:0];
		aoff_s1   = off_s1 - TILE_END;
		tile_s1   = off_s1 < TILE_END;
		changed   = nt_wr_s1 && (old_byte != wdata_s1);
		for (int g = 0; g < 4; g++)
			fc[g] = old_byte[2*g +: 2] != wdata_s1[2*g +: 2];
		tile_mask = 32'd1 << off_s1[4:0];
		mask_top  = (fc[0] ? (32'd3 << {aoff_s1[2:0], 2'b00}) : 32'd0)
			| (fc[1] ? (32'd3 << {aoff_s1[2:0], 2'b10}) : 32'd0);
		mask_bot  = (fc[2] ? (32'd3 << {aoff_s1[2:0], 2'b00}) : 32'd0)
			| (fc[3] ? (32'd3 << {aoff_s1[2:0], 2'b10}) : 32'd0);
		for (int b = 0; b < vrm_pkg::DIRTY_BANKS; b++) begin
			if (tile_s1) begin
				upd.mask[b] = tile_mask;
				upd.we[b]   = s1_fire && changed && (off_s1[6:5] == 2'(b));
			end else begin
				upd.mask[b] = (b < vrm_pkg::DIRTY_BANKS / 2) ? mask_top : mask_bot;
				upd.we[b]   = s1_fire && changed && (upd.mask[b] != 32'd0);
			end
		end
		clr.en  = s1_fire && (cmd_s1 == vrm_pkg::CMD_CLR_DIRTY);
		clr.tbl = sel_s1;
	end

	vrm_dirty_store u_dirty (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (req_acc),
		.rd_addr (daddr_in),
		.upd     (upd),
		.clr     (clr),
		.cur     (cur)
	);

	// Palette entries 0x10/0x14/0x18/0x1C alias down by 16
	assign pslot_s1 = {addr_s1[4] & (addr_s1[1:0] != 2'b00), addr_s1[3:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_q <= '0;
		end else if (s1_fire && (cmd_s1 == vrm_pkg::CMD_WRITE)
			&& (region_s1 == vrm_pkg::RGN_PALETTE)) begin
			pal_q[pslot_s1] <= wdata_s1;
		end
	end

	// Raise refresh on a changed byte, drop it on clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refresh_q <= '0;
		end else if (s1_fire) begin
			if (changed)
				refresh_q[tidx_s1] <= 1'b1;
			else if (cmd_s1 == vrm_pkg::CMD_CLR_DIRTY)
				refresh_q[sel_s1] <= 1'b0;
		end
	end

	// Build the result
	always_comb begin
		rd_nx      = 8'd0;
		handled_nx = 1'b1;
		word_nx    = 32'd0;
		pend_nx    = 1'b0;
		case (cmd_s1)
			vrm_pkg::CMD_READ: begin
				if (region_s1 == vrm_pkg::RGN_PATTERN)
					handled_nx = 1'b0;
				else if (region_s1 == vrm_pkg::RGN_NAME)
					rd_nx = old_byte;
				else
					rd_nx = pal_q[pslot_s1];
			end
			vrm_pkg::CMD_WRITE: begin
				if (region_s1 == vrm_pkg::RGN_PATTERN)
					handled_nx = 1'b0;
			end
			vrm_pkg::CMD_RD_DIRTY: begin
				word_nx = cur[row_s1[1:0]];
				pend_nx = refresh_q[sel_s1];
			end
			default: begin
			end
		endcase
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (s1_fire) begin
			rsp_valid <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			read_data       <= rd_nx;
			handled         <= handled_nx;
			dirty_word      <= word_nx;
			refresh_pending <= pend_nx;
		end
	end

	// No transaction enters while the RAM is being cleared
	a_no_acc_clr: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !req_ready)
		else $error("transaction accepted during clearing pass");

	// A stage-one advance always lands in the result register
	a_fire_out: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire |=> rsp_valid)
		else $error("stage one advanced without a result");

	// A stalled stage one keeps its transaction
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !s1_fire |=> s1_valid_q && $stable(cmd_s1) && $stable(addr_s1))
		else $error("stage one lost its transaction while stalled");

	// Unhandled accesses return no data
	a_unhandled: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !handled |-> read_data == 8'd0 && dirty_word == 32'd0)
		else $error("unhandled access returned data");

	// A changed nametable byte raises its table's refresh flag
	a_refresh: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && changed |=> refresh_q[$past(tidx_s1)])
		else $error("refresh flag not raised by changed byte");

endmodule

### hdl/vrm_dirty_store.sv
// Dirty bit store: four banks of 32-bit rows, one valid bit per row, with
// forwarding of the previous update. Depends on vrm_pkg.
module vrm_dirty_store (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        rd_en,
	input  logic [vrm_pkg::DADDR_W-1:0]                 rd_addr,
	input  vrm_pkg::dirty_upd_t                         upd,
	input  vrm_pkg::dirty_clr_t                         clr,
	output logic [vrm_pkg::DIRTY_BANKS-1:0][31:0]       cur
);

	logic [vrm_pkg::DADDR_W-1:0]                        addr_q;
	logic [vrm_pkg::DIRTY_BANKS-1:0][vrm_pkg::DDEPTH-1:0] val_q;
	logic [vrm_pkg::DIRTY_BANKS-1:0]                    fwd_q;
	logic [vrm_pkg::DIRTY_BANKS-1:0][31:0]              fwd_data_q;
	logic [vrm_pkg::DIRTY_BANKS-1:0][31:0]              rd_q;
	logic [vrm_pkg::DIRTY_BANKS-1:0][31:0]              wval;

	// Hold the row group of the transaction in stage one
	always_ff @(posedge clk) begin
		if (rd_en)
			addr_q <= rd_addr;
	end

	genvar b;
	generate
		for (b = 0; b < vrm_pkg::DIRTY_BANKS; b++) begin : g_bank
			logic [31:0] mem [vrm_pkg::DDEPTH];

			always_ff @(posedge clk) begin
				if (upd.we[b])
					mem[addr_q] <= wval[b];
			end

			always_ff @(posedge clk) begin
				if (rd_en)
					rd_q[b] <= mem[rd_addr];
			end

			// Forward a write that lands on the row group just read
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					fwd_q[b] <= 1'b0;
				end else if (rd_en) begin
					fwd_q[b] <= upd.we[b] && (addr_q == rd_addr);
				end
			end

			always_ff @(posedge clk) begin
				if (rd_en)
					fwd_data_q[b] <= wval[b];
			end

			// A row never written since reset or clear reads as zero
			assign cur[b]  = val_q[b][addr_q] ? (fwd_q[b] ? fwd_data_q[b] : rd_q[b]) : 32'd0;
			assign wval[b] = cur[b] | upd.mask[b];
		end
	endgenerate

	// Set valid on update, drop all rows of a cleared table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
		end else begin
			for (int i = 0; i < vrm_pkg::DIRTY_BANKS; i++) begin
				for (int e = 0; e < vrm_pkg::DDEPTH; e++) begin
					if (clr.en && (vrm_pkg::TIDX_W'(e >> vrm_pkg::DGRP_W) == clr.tbl))
						val_q[i][e] <= 1'b0;
					else if (upd.we[i] && (addr_q == vrm_pkg::DADDR_W'(e)))
						val_q[i][e] <= 1'b1;
				end
			end
		end
	end

endmodule

### dv/vram_tb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the video RAM mirror and dirty tracker: a shadow of the nametable,
// palette, dirty matrix and refresh flags, plus a queue of predicted bus replies.
// Depends on vrm_pkg.
package vram_tb_pkg;
	import vrm_pkg::*;

	// Mirror mode encodings not named in vrm_pkg; the reserved ones act as four-screen
	localparam logic [2:0] MODE_FOUR   = 3'd4;
	localparam logic [2:0] MODE_RSVD5  = 3'd5;
	localparam logic [2:0] MODE_RSVD6  = 3'd6;
	localparam logic [2:0] MODE_RSVD7  = 3'd7;

	typedef struct packed {
		logic [7:0]  read_data;
		logic        handled;
		logic [31:0] dirty_word;
		logic        refresh_pending;
	} bus_reply_t;

	class vram_scoreboard;
		bit [2:0]   mode;
		bit [7:0]   name_mem [TBL_DEPTH];
		bit [7:0]   pal_mem [32];
		bit [31:0]  dirty_mem [PHYS_TABLES * DIRTY_ROWS];
		bit         refresh [PHYS_TABLES];
		bus_reply_t reply_q [$];
		int         errors;

		function int outstanding();
			return reply_q.size();
		endfunction

		function void set_mode(bit [2:0] m);
			mode = m;
		endfunction

		// Fold a table index past the last physical table back by two
		function bit [1:0] fold_table(bit [1:0] idx);
			if (int'(idx) >= PHYS_TABLES)
				return idx - 2'd2;
			return idx;
		endfunction

		// Logical quadrant of a nametable address to physical table
		function bit [1:0] mirrored_table(bit [13:0] addr);
			bit [2:0] m;
			bit [1:0] q;
			bit [1:0] idx;
			m = (mode > MODE_FOUR) ? MODE_FOUR : mode;
			q = addr[11:10];
			case (m)
				MIR_VERT:    idx = {1'b0, q[1]};
				MIR_HORIZ:   idx = {1'b0, q[0]};
				MIR_SINGLE0: idx = 2'd0;
				MIR_SINGLE1: idx = 2'd1;
				default:     idx = q;
			endcase
			return fold_table(idx);
		endfunction

		// Entries 0x10/0x14/0x18/0x1C alias down by 16
		function bit [4:0] palette_slot_of(bit [13:0] addr);
			bit [4:0] s;
			s = addr[4:0];
			if (s[4] && s[1:0] == 2'd0)
				s[4] = 1'b0;
			return s;
		endfunction

		function void mark_rows(int t, int row, bit [31:0] mask);
			if (row < DIRTY_ROWS)
				dirty_mem[t * DIRTY_ROWS + row] |= mask;
		endfunction

		// Store a nametable byte and mark what a changed byte repaints
		function void store_name_byte(bit [13:0] addr, bit [7:0] data);
			int t, off, pos, g, y, x;
			bit [7:0]  old;
			bit [31:0] mask;
			t = mirrored_table(addr);
			off = addr[9:0];
			pos = t * TBL_SIZE + off;
			old = name_mem[pos];
			name_mem[pos] = data;
			if (old == data)
				return;
			refresh[t] = 1'b1;
			if (off < TILE_BYTES) begin
				mark_rows(t, off / 32, 32'd1 << (off % 32));
				return;
			end
			// Attribute byte: each changed 2-bit field covers a 2x2 tile block
			off -= TILE_BYTES;
			for (g = 0; g < 4; g++) begin
				if (old[2*g +: 2] != data[2*g +: 2]) begin
					y = (off / 8) * 4 + ((g >= 2) ? 2 : 0);
					x = (off % 8) * 4 + ((g % 2 != 0) ? 2 : 0);
					mask = 32'd3 << x;
					mark_rows(t, y, mask);
					mark_rows(t, y + 1, mask);
				end
			end
		endfunction

		// Predict the reply of one accepted access and update the shadow
		function void note_access(cmd_t cmd, bit [15:0] address, bit [7:0] wdata,
				bit [1:0] tsel, bit [4:0] row);
			bus_reply_t e;
			bit [13:0]  a;
			int         t, r;
			a = address[13:0];
			t = fold_table(tsel);
			e = '0;
			e.handled = 1'b1;
			case (cmd)
				CMD_READ: begin
					if (a < 14'h2000)
						e.handled = 1'b0;
					else if (a < 14'h3F00)
						e.read_data = name_mem[int'(mirrored_table(a)) * TBL_SIZE + a[9:0]];
					else
						e.read_data = pal_mem[palette_slot_of(a)];
				end
				CMD_WRITE: begin
					if (a < 14'h2000)
						e.handled = 1'b0;
					else if (a < 14'h3F00)
						store_name_byte(a, wdata);
					else
						pal_mem[palette_slot_of(a)] = wdata;
				end
				CMD_RD_DIRTY: begin
					e.dirty_word = dirty_mem[t * DIRTY_ROWS + row];
					e.refresh_pending = refresh[t];
				end
				default: begin
					for (r = 0; r < DIRTY_ROWS; r++)
						dirty_mem[t * DIRTY_ROWS + r] = '0;
					refresh[t] = 1'b0;
				end
			endcase
			reply_q.push_back(e);
		endfunction

		task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
			errors++;
			if (errors <= 100)
				$display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
		endtask

		// Compare one delivered reply with the oldest prediction
		task check_reply(logic [7:0] rd, logic hd, logic [31:0] dw, logic rp);
			bus_reply_t e;
			if (reply_q.size() == 0) begin
				report_mismatch("unsolicited reply", {rd, 23'd0, hd}, '0);
				return;
			end
			e = reply_q.pop_front();
			if (rd !== e.read_data)
				report_mismatch("read_data", rd, e.read_data);
			if (hd !== e.handled)
				report_mismatch("handled", hd, e.handled);
			if (dw !== e.dirty_word)
				report_mismatch("dirty_word", dw, e.dirty_word);
			if (rp !== e.refresh_pending)
				report_mismatch("refresh_pending", rp, e.refresh_pending);
		endtask
	endclass

endpackage

### dv/tb_video_ram_mirror_dirty_tracker.sv
`timescale 1ns / 100ps
// Testbench for video_ram_mirror_dirty_tracker: directed and random bus accesses under
// every mirror mode, with random idling and back-pressure. Depends on vrm_pkg, vram_tb_pkg.
module tb_video_ram_mirror_dirty_tracker;
	import vrm_pkg::*;
	import vram_tb_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [2:0]  cfg_wr_data = '0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	logic [1:0]  command = CMD_READ;
	logic [15:0] address = '0;
	logic [7:0]  write_data = '0;
	logic [1:0]  table_select = '0;
	logic [4:0]  dirty_row = '0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	logic [7:0]  read_data;
	logic        handled;
	logic [31:0] dirty_word;
	logic        refresh_pending;

	bit tx_idle_en = 1'b1;
	bit rx_idle_en = 1'b1;
	bit hold_req   = 1'b0;
	bit hold_done  = 1'b0;

	vram_scoreboard sb = new();

	video_ram_mirror_dirty_tracker u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.req_valid       (req_valid),
		.req_ready       (req_ready),
		.command         (command),
		.address         (address),
		.write_data      (write_data),
		.table_select    (table_select),
		.dirty_row       (dirty_row),
		.rsp_valid       (rsp_valid),
		.rsp_ready       (rsp_ready),
		.read_data       (read_data),
		.handled         (handled),
		.dirty_word      (dirty_word),
		.refresh_pending (refresh_pending)
	);

	always #2 clk = ~clk;

	// Watch both channels; replies first, since an access this edge cannot answer yet
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready)
				sb.check_reply(read_data, handled, dirty_word, refresh_pending);
			if (req_valid && req_ready)
				sb.note_access(cmd_t'(command), address, write_data, table_select, dirty_row);
		end
	end

	// Reply side: random stalls, plus one long hold-off when requested
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_left = 300;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else if (rx_idle_en) begin
				rsp_ready <= ($urandom_range(99) >= 14);
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// Offer one access and hold it until the design accepts it
	task automatic send_item(cmd_t c, logic [15:0] a, logic [7:0] d, logic [1:0] s,
			logic [4:0] r);
		while (tx_idle_en && $urandom_range(99) < 14) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid    <= 1'b1;
		command      <= c;
		address      <= a;
		write_data   <= d;
		table_select <= s;
		dirty_row    <= r;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
	endtask

	// Mostly well-formed accesses with random content, some raw noise
	task automatic send_random_item();
		int         pick;
		logic [13:0] a;
		logic [1:0]  hi;
		logic [7:0]  d;
		cmd_t        c;
		pick = $urandom_range(99);
		hi = 2'($urandom_range(3));
		// small values make unchanged writes and single-field attribute changes common
		d = ($urandom_range(1) != 0) ? 8'($urandom_range(255)) : 8'($urandom_range(3));
		a = 14'h2000 + 14'($urandom_range(14'h1EFF));
		if (pick < 30) begin
			c = CMD_WRITE;
			if ($urandom_range(2) == 0)
				a = {2'b10, 2'($urandom_range(3)), 10'h3C0 + 10'($urandom_range(63))};
		end else if (pick < 50) begin
			c = CMD_READ;
		end else if (pick < 58) begin
			c = CMD_WRITE;
			a = 14'h3F00 + 14'($urandom_range(255));
		end else if (pick < 64) begin
			c = CMD_READ;
			a = 14'h3F00 + 14'($urandom_range(255));
		end else if (pick < 82) begin
			c = CMD_RD_DIRTY;
		end else if (pick < 86) begin
			c = CMD_CLR_DIRTY;
		end else begin
			c = cmd_t'($urandom_range(3));
			a = 14'($urandom_range(16'hFFFF));
		end
		send_item(c, {hi, a}, d, 2'($urandom_range(3)), 5'($urandom_range(31)));
	endtask

	// Wait, bounded, until every predicted reply has been delivered
	task automatic wait_drain();
		int n;
		n = 0;
		while (sb.outstanding() != 0 && n < 20000) begin
			@(posedge clk);
			n++;
		end
	endtask

	task automatic write_mode(logic [2:0] m);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= m;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		sb.set_mode(m);
	endtask

	// Drain, reprogram the mirror mode, then run a batch of random accesses
	task automatic run_phase(logic [2:0] m, int n, bit stall);
		wait_drain();
		repeat (4) @(posedge clk);
		write_mode(m);
		if (stall)
			hold_req = 1'b1;
		repeat (n) send_random_item();
		req_valid <= 1'b0;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed accesses at the reset mirror mode
		send_item(CMD_READ,      16'h2000, 8'h00, 2'd0, 5'd0);
		send_item(CMD_WRITE,     16'h2000, 8'hA5, 2'd0, 5'd0);
		send_item(CMD_WRITE,     16'h2000, 8'hA5, 2'd0, 5'd0);
		send_item(CMD_READ,      16'h2400, 8'h00, 2'd0, 5'd0);
		send_item(CMD_WRITE,     16'h0000, 8'hFF, 2'd0, 5'd0);
		send_item(CMD_READ,      16'h1FFF, 8'h00, 2'd0, 5'd0);
		send_item(CMD_WRITE,     16'hC000, 8'hFF, 2'd3, 5'd31);
		send_item(CMD_WRITE,     16'h23C0, 8'hFF, 2'd0, 5'd0);
		send_item(CMD_WRITE,     16'h27FF, 8'h0C, 2'd0, 5'd0);
		send_item(CMD_WRITE,     16'h2BBF, 8'h01, 2'd0, 5'd0);
		send_item(CMD_WRITE,     16'h3EFF, 8'hFF, 2'd0, 5'd0);
		send_item(CMD_READ,      16'h3EFF, 8'h00, 2'd0, 5'd0);
		send_item(CMD_WRITE,     16'h2800, 8'h00, 2'd0, 5'd0);
		send_item(CMD_RD_DIRTY,  16'h0000, 8'h00, 2'd0, 5'd0);
		send_item(CMD_RD_DIRTY,  16'h0000, 8'h00, 2'd0, 5'd1);
		send_item(CMD_RD_DIRTY,  16'h0000, 8'h00, 2'd0, 5'd29);
		send_item(CMD_RD_DIRTY,  16'h0000, 8'h00, 2'd1, 5'd29);
		send_item(CMD_RD_DIRTY,  16'hFFFF, 8'hFF, 2'd3, 5'd31);
		send_item(CMD_WRITE,     16'h3F10, 8'h3F, 2'd0, 5'd0);
		send_item(CMD_READ,      16'h3F00, 8'h00, 2'd0, 5'd0);
		send_item(CMD_WRITE,     16'h3F1F, 8'hC3, 2'd0, 5'd0);
		send_item(CMD_READ,      16'hFFFF, 8'h00, 2'd0, 5'd0);
		send_item(CMD_CLR_DIRTY, 16'h0000, 8'h00, 2'd0, 5'd0);
		send_item(CMD_RD_DIRTY,  16'h0000, 8'h00, 2'd0, 5'd0);
		send_item(CMD_CLR_DIRTY, 16'h0000, 8'h00, 2'd3, 5'd0);
		send_item(CMD_READ,      16'h3F14, 8'h00, 2'd0, 5'd0);
		req_valid <= 1'b0;

		// Random phases over all mirror modes, reserved encodings included
		run_phase(MODE_FOUR, 110, 1'b0);
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		run_phase(MIR_HORIZ, 120, 1'b0);
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		run_phase(MIR_SINGLE0, 110, 1'b1);
		run_phase(MIR_SINGLE1, 100, 1'b0);
		run_phase(MODE_RSVD7, 100, 1'b0);
		run_phase(MODE_RSVD5, 100, 1'b0);
		run_phase(MODE_RSVD6, 100, 1'b0);
		run_phase(MIR_VERT, 100, 1'b0);
		run_phase(MODE_FOUR, 100, 1'b0);

		wait_drain();
		repeat (8) @(posedge clk);
		if (sb.outstanding() != 0)
			sb.report_mismatch("undelivered replies", sb.outstanding(), '0);
		if (sb.errors == 0)
			$display("PASS video_ram_mirror_dirty_tracker");
		else
			$display("FAIL video_ram_mirror_dirty_tracker");
		$finish;
	end

	// Watchdog
	initial begin
		#400us;
		$display("FAIL video_ram_mirror_dirty_tracker");
		$finish;
	end

endmodule

### filelist.f
hdl/vrm_pkg.sv
hdl/vrm_dirty_store.sv
hdl/video_ram_mirror_dirty_tracker.sv
dv/vram_tb_pkg.sv
dv/tb_video_ram_mirror_dirty_tracker.sv
